// ===== rtl/png_scanline_unfilter_macros.svh =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter_macros
// assertion helpers shared by the unfilter rtl
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication, reset masked
`define PSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// constants, filter codes and predictor functions for scanline unfiltering
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 8192;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    localparam int BPP_W      = 4;
    localparam int ROW_LEN_W  = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 1'b1;

    localparam logic [BPP_W-1:0]     BPP_RESET     = 4'd3;
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 14'd3;

    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    function automatic logic [7:0] paeth_pick(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c
    );
        logic signed [10:0] pa_s;
        logic signed [10:0] pb_s;
        logic signed [10:0] pc_s;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [7:0] pick;
        pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
        pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
        pc_s = $signed({3'b000, a}) + $signed({3'b000, b})
             - $signed({2'b00, c, 1'b0});
        pa = pa_s[10] ? 10'(-pa_s) : pa_s[9:0];
        pb = pb_s[10] ? 10'(-pb_s) : pb_s[9:0];
        pc = pc_s[10] ? 10'(-pc_s) : pc_s[9:0];
        if (pa <= pb && pa <= pc)
        begin
            pick = a;
        end
        else if (pb <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

    function automatic logic [7:0] predict(
        input logic [7:0] ftype,
        input logic [7:0] left,
        input logic [7:0] up,
        input logic [7:0] ul
    );
        logic [8:0] sum;
        logic [7:0] pred;
        sum = {1'b0, left} + {1'b0, up};
        unique case (ftype)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = sum[8:1];
            FILT_PAETH: pred = paeth_pick(left, up, ul);
            default:    pred = 8'd0;
        endcase
        return pred;
    endfunction

endpackage

// ===== rtl/psu_line_buf.sv =====
// ----------------------------------------------------------------------------
// psu_line_buf
// prior row store, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psu_line_buf #(
    parameter int DEPTH = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// png filter reconstruction (none, sub, up, average, paeth) on a byte stream
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless pixel_ready stalls the output. The first
// byte of each row is the filter type and gives no output; every other byte
// passes the stage one and result registers and comes out reconstructed. The
// first stage tracks the column and launches the prior-row read; the second
// writes the predicted result into the line buffer (one read, one write port).
// An image's first row has a zero up neighbour, a row's first pixel zero left
// ones. Rows with a filter type above four pass raw with unknown_filter set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           data_valid,
    output logic                           data_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           first_of_image,

    output logic                           pixel_valid,
    input  logic                           pixel_ready,
    output logic [7:0]                     pixel_byte,
    output logic                           last_of_row,
    output logic                           unknown_filter
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int CW = AW + 1;
    localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BW = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int LW = (CW > psu_pkg::ROW_LEN_W) ? CW : psu_pkg::ROW_LEN_W;
    localparam int XW = (AW > BW) ? AW : BW;

    // configuration
    logic [psu_pkg::BPP_W-1:0]     bpp_raw_reg, bpp_raw_next;
    logic [psu_pkg::ROW_LEN_W-1:0] row_len_reg, row_len_next;
    logic [BW-1:0]                 bpp_eff;
    logic [HW-1:0]                 bpp_m1;
    logic [LW-1:0]                 row_len_w;
    logic [CW-1:0]                 len_eff;

    // front end
    logic [CW-1:0]  col_pos_reg, col_pos_next;
    logic [7:0]     ftype_reg, ftype_next;
    logic           first_row_reg, first_row_next;
    logic [CW-1:0]  pos;
    logic           first_row_eff;
    logic           is_filter;
    logic [AW-1:0]  col;
    logic           last;
    logic           data_fire;
    logic           load_s1;

    // compute stage
    logic           s1_valid_reg, s1_valid_next;
    logic [7:0]     s1_byte_reg, s1_byte_next;
    logic [AW-1:0]  s1_col_reg, s1_col_next;
    logic [7:0]     s1_ftype_reg, s1_ftype_next;
    logic           s1_first_row_reg, s1_first_row_next;
    logic           s1_last_reg, s1_last_next;
    logic           s1_left_ok_reg, s1_left_ok_next;
    logic           s1_fire;
    logic [7:0]     up_raw;
    logic [7:0]     up;
    logic [7:0]     left;
    logic [7:0]     ul;
    logic [7:0]     res;

    logic [7:0]     lh_reg [MAX_PIXEL_BYTES];
    logic [7:0]     lh_next [MAX_PIXEL_BYTES];
    logic [7:0]     ulh_reg [MAX_PIXEL_BYTES];
    logic [7:0]     ulh_next [MAX_PIXEL_BYTES];

    // result register
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_last_reg, out_last_next;
    logic           out_unknown_reg, out_unknown_next;

    // configuration registers, clamped at use
    always_comb
    begin
        bpp_raw_next = bpp_raw_reg;
        row_len_next = row_len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                psu_pkg::CFG_BYTES_PER_PIXEL: bpp_raw_next = cfg_data[psu_pkg::BPP_W-1:0];
                psu_pkg::CFG_ROW_BYTES:       row_len_next = cfg_data[psu_pkg::ROW_LEN_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        if (bpp_raw_reg == '0)
        begin
            bpp_eff = BW'(1);
        end
        else if (bpp_raw_reg > psu_pkg::BPP_W'(MAX_PIXEL_BYTES))
        begin
            bpp_eff = BW'(MAX_PIXEL_BYTES);
        end
        else
        begin
            bpp_eff = BW'(bpp_raw_reg);
        end
        bpp_m1 = HW'(bpp_eff - BW'(1));

        row_len_w = LW'(row_len_reg);
        if (row_len_w == '0)
        begin
            len_eff = CW'(1);
        end
        else if (row_len_w > LW'(MAX_ROW_BYTES))
        begin
            len_eff = CW'(MAX_ROW_BYTES);
        end
        else
        begin
            len_eff = CW'(row_len_w);
        end
    end

    // handshake
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || pixel_ready);
    assign data_ready = !s1_valid_reg || s1_fire;
    assign data_fire  = data_valid && data_ready;

    // column tracking and stage one
    always_comb
    begin
        pos           = first_of_image ? '0 : col_pos_reg;
        first_row_eff = first_of_image ? 1'b1 : first_row_reg;
        is_filter     = (pos == '0);
        col           = AW'(pos - CW'(1));
        last          = (pos >= len_eff);
        load_s1       = data_fire && !is_filter;

        col_pos_next   = col_pos_reg;
        ftype_next     = ftype_reg;
        first_row_next = first_row_reg;
        if (data_fire)
        begin
            priority if (is_filter)
            begin
                ftype_next     = data_byte;
                col_pos_next   = CW'(1);
                first_row_next = first_row_eff;
            end
            else if (last)
            begin
                col_pos_next   = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_pos_next   = pos + CW'(1);
                first_row_next = first_row_eff;
            end
        end

        s1_byte_next      = s1_byte_reg;
        s1_col_next       = s1_col_reg;
        s1_ftype_next     = s1_ftype_reg;
        s1_first_row_next = s1_first_row_reg;
        s1_last_next      = s1_last_reg;
        s1_left_ok_next   = s1_left_ok_reg;
        if (load_s1)
        begin
            s1_byte_next      = data_byte;
            s1_col_next       = col;
            s1_ftype_next     = ftype_reg;
            s1_first_row_next = first_row_eff;
            s1_last_next      = last;
            s1_left_ok_next   = (XW'(col) >= XW'(bpp_eff));
        end

        priority if (load_s1)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    psu_line_buf #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (AW)
    ) u_line_buf (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (res),
        .re    (load_s1),
        .raddr (col),
        .rdata (up_raw)
    );

    // reconstruction
    always_comb
    begin
        up   = s1_first_row_reg ? 8'd0 : up_raw;
        left = s1_left_ok_reg ? lh_reg[bpp_m1] : 8'd0;
        ul   = s1_left_ok_reg ? ulh_reg[bpp_m1] : 8'd0;
        res  = s1_byte_reg + psu_pkg::predict(s1_ftype_reg, left, up, ul);
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++)
        begin
            lh_next[k]  = lh_reg[k];
            ulh_next[k] = ulh_reg[k];
        end
        if (s1_fire)
        begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--)
            begin
                lh_next[k]  = lh_reg[k-1];
                ulh_next[k] = ulh_reg[k-1];
            end
            lh_next[0]  = res;
            ulh_next[0] = up;
        end
    end

    // result register
    always_comb
    begin
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_unknown_next = out_unknown_reg;
        priority if (s1_fire)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = res;
            out_last_next    = s1_last_reg;
            out_unknown_next = (s1_ftype_reg > psu_pkg::FILT_PAETH);
        end
        else if (pixel_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_raw_reg   <= psu_pkg::BPP_RESET;
            row_len_reg   <= psu_pkg::ROW_LEN_RESET;
            col_pos_reg   <= '0;
            ftype_reg     <= psu_pkg::FILT_NONE;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bpp_raw_reg   <= bpp_raw_next;
            row_len_reg   <= row_len_next;
            col_pos_reg   <= col_pos_next;
            ftype_reg     <= ftype_next;
            first_row_reg <= first_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg      <= s1_byte_next;
        s1_col_reg       <= s1_col_next;
        s1_ftype_reg     <= s1_ftype_next;
        s1_first_row_reg <= s1_first_row_next;
        s1_last_reg      <= s1_last_next;
        s1_left_ok_reg   <= s1_left_ok_next;
        out_byte_reg     <= out_byte_next;
        out_last_reg     <= out_last_next;
        out_unknown_reg  <= out_unknown_next;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++)
        begin
            lh_reg[k]  <= lh_next[k];
            ulh_reg[k] <= ulh_next[k];
        end
    end

    assign pixel_valid    = out_valid_reg;
    assign pixel_byte     = out_byte_reg;
    assign last_of_row    = out_last_reg;
    assign unknown_filter = out_unknown_reg;

    // checks
    `PSU_ASSERT_IMPL(a_col_in_range, 1'b1, col_pos_reg <= CW'(MAX_ROW_BYTES), "column past row store")
    `PSU_ASSERT_NEXT(a_row_wrap, load_s1 && last, col_pos_reg == '0, "row end did not wrap")
    `PSU_ASSERT_NEXT(a_filter_step, data_fire && is_filter, col_pos_reg == CW'(1), "filter item lost")
    `PSU_ASSERT_IMPL(a_out_from_s1, $rose(out_valid_reg), $past(s1_valid_reg), "result without item")

endmodule
